>>> rtl/rmrt_pkg.sv
`default_nettype none
package rmrt_pkg;

  localparam int unsigned MaxEntries  = 50;
  localparam int unsigned TopPriority = 99;
  localparam int unsigned TaskW       = 22;
  localparam int unsigned TimeW       = 48;
  localparam int unsigned PrioW       = 7;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_CANCEL  = 2'd1,
    OP_EXIT    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TIMES    = 3'd1,
    ST_NOTASK   = 3'd2,
    ST_DUP      = 3'd3,
    ST_FULL     = 3'd4,
    ST_NOTFOUND = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [TaskW-1:0] task_id;
    logic [TimeW-1:0] budget_ns;
    logic [TimeW-1:0] period_ns;
    logic             task_exists;
  } in_word_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [TaskW-1:0] out_task_id;
    logic [PrioW-1:0] priority_res;
    logic             last;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FIND,
    S_SHIFT,
    S_ERR,
    S_CANREP,
    S_RANKSCAN,
    S_EMIT,
    S_APPEND
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic       load_in;
    logic       clr_idx;
    logic       inc_idx;
    logic       shift_step;
    logic       dec_count;
    logic       append;
    logic       clr_rank;
    logic       rank_step;
    logic       take_min;
    logic       emit_err;
    logic       emit_can;
    logic       emit_rank;
    logic [2:0] err_code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       times_bad;
    logic       exists;
    logic       idx_end;
    logic       hit;
    logic       shift_end;
    logic       full;
    logic       empty;
    logic       rank_end;
    logic       scan_end;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/rate_monotonic_reservation_table.sv
// Rate-monotonic reservation table. Words on in_* carry reserve, cancel and
// exit requests; each gives zero to MAX_ENTRIES result words on out_*, the
// final one flagged by last. One request is handled at a time: the id search
// and the removal shift walk the table one slot per cycle, and ranking is a
// selection sort with one scan of the table per emitted entry. Equal periods
// rank in insertion order. An output register decouples result delivery from
// the ranking scan.
`default_nettype none
module rate_monotonic_reservation_table
  import rmrt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES  = MaxEntries,
  parameter int unsigned TOP_PRIORITY = TopPriority
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_word_t  out_data
);

  cmd_t cmd;   // controller commands
  sts_t sts;   // datapath status

  rmrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .sts_i(sts), .cmd_o(cmd)
  );

  rmrt_dp #(.MAX_ENTRIES(MAX_ENTRIES), .TOP_PRIORITY(TOP_PRIORITY)) u_dp (
    .clk_i, .rst_ni, .in_data, .cmd_i(cmd), .sts_o(sts),
    .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

>>> rtl/rmrt_ctrl.sv
`default_nettype none
module rmrt_ctrl
  import rmrt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid,
  output logic       in_ready,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    in_ready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load_in = 1'b1;
          cmd_o.clr_idx = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        unique case (sts_i.op)
          OP_RESERVE: begin
            if (sts_i.times_bad) begin
              cmd_o.err_code = ST_TIMES;
              state_d = S_ERR;
            end else if (!sts_i.exists) begin
              cmd_o.err_code = ST_NOTASK;
              state_d = S_ERR;
            end else begin
              state_d = S_FIND;
            end
          end
          OP_CANCEL, OP_EXIT: state_d = S_FIND;
          default:            state_d = S_IDLE;
        endcase
      end
      // linear search, one slot a cycle
      S_FIND: begin
        if (sts_i.hit) begin
          if (sts_i.op == OP_RESERVE) begin
            cmd_o.err_code = ST_DUP;
            state_d = S_ERR;
          end else begin
            // step past the hit so the next slot is read for the shift
            cmd_o.inc_idx = 1'b1;
            state_d = S_SHIFT;
          end
        end else if (sts_i.idx_end) begin
          if (sts_i.op == OP_RESERVE) begin
            if (sts_i.full) begin
              cmd_o.err_code = ST_FULL;
              state_d = S_ERR;
            end else begin
              cmd_o.append = 1'b1;
              state_d = S_APPEND;
            end
          end else if (sts_i.op == OP_CANCEL) begin
            cmd_o.err_code = ST_NOTFOUND;
            state_d = S_ERR;
          end else begin
            cmd_o.clr_rank = 1'b1;
            state_d = S_RANKSCAN;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      S_ERR: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_err = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_APPEND: begin
        cmd_o.clr_rank = 1'b1;
        state_d = S_RANKSCAN;
      end
      S_SHIFT: begin
        if (sts_i.shift_end) begin
          cmd_o.dec_count = 1'b1;
          state_d = (sts_i.op == OP_CANCEL) ? S_CANREP : S_RANKSCAN;
          cmd_o.clr_rank = 1'b1;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_CANREP: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_can = 1'b1;
          state_d = S_RANKSCAN;
        end
      end
      // one selection pass per rank
      S_RANKSCAN: begin
        if (sts_i.rank_end) begin
          state_d = S_IDLE;
        end else if (sts_i.scan_end) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rank_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit_rank = 1'b1;
          cmd_o.take_min  = 1'b1;
          state_d = S_RANKSCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/rmrt_dp.sv
`default_nettype none
module rmrt_dp
  import rmrt_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES  = MaxEntries,
  parameter int unsigned TOP_PRIORITY = TopPriority
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  in_word_t   in_data,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  output logic       out_valid,
  input  wire        out_ready,
  output out_word_t  out_data
);

  localparam int unsigned IdxW = $clog2(MAX_ENTRIES + 1);

  logic [TaskW-1:0] task_q [MAX_ENTRIES];
  logic [TimeW-1:0] per_q  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] used_q;   // already ranked

  in_word_t         req_q;
  logic [IdxW-1:0]  cnt_q, idx_q, rank_q, best_q;
  logic [TimeW-1:0] best_per_q;
  logic [TaskW-1:0] best_task_q;
  logic             best_ok_q;
  logic [2:0]       err_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic [IdxW-1:0]  idx_nx, idx_d, rd_addr;
  logic [TaskW-1:0] rd_task_q;
  logic [TimeW-1:0] rd_per_q;
  logic [PrioW-1:0] prio;

  assign idx_nx = idx_q + 1'b1;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.clr_idx || cmd_i.clr_rank || cmd_i.take_min) idx_d = '0;
    else if (cmd_i.inc_idx || cmd_i.shift_step || cmd_i.rank_step) idx_d = idx_nx;
  end

  // read port follows the slot pointer, data past the end is never used
  assign rd_addr = (idx_d < IdxW'(MAX_ENTRIES)) ? idx_d : '0;

  always_comb begin
    if (32'(rank_q) >= TOP_PRIORITY - 1) prio = PrioW'(1);
    else prio = PrioW'(TOP_PRIORITY) - PrioW'(rank_q);
  end

  assign sts_o.op        = req_q.op;
  assign sts_o.times_bad = (req_q.budget_ns == '0) || (req_q.period_ns == '0) ||
                           (req_q.budget_ns > req_q.period_ns);
  assign sts_o.exists    = req_q.task_exists;
  assign sts_o.idx_end   = (idx_q >= cnt_q);
  assign sts_o.hit       = (idx_q < cnt_q) && (rd_task_q == req_q.task_id);
  assign sts_o.shift_end = (idx_q >= cnt_q);
  assign sts_o.full      = (cnt_q >= IdxW'(MAX_ENTRIES));
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.rank_end  = (rank_q >= cnt_q);
  assign sts_o.scan_end  = (idx_q >= cnt_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready;

  // table storage, shifted down one slot per cycle on removal
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_step) begin
      task_q[idx_q - 1'b1] <= rd_task_q;
      per_q[idx_q - 1'b1]  <= rd_per_q;
    end
    if (cmd_i.append) begin
      task_q[cnt_q] <= req_q.task_id;
      per_q[cnt_q]  <= req_q.period_ns;
    end
    rd_task_q <= task_q[rd_addr];
    rd_per_q  <= per_q[rd_addr];
    if (cmd_i.load_in) req_q <= in_data;
    if (cmd_i.emit_err || cmd_i.emit_can || cmd_i.emit_rank) begin
      if (cmd_i.emit_err) begin
        out_q.status       <= err_q;
        out_q.out_task_id  <= req_q.task_id;
        out_q.priority_res <= '0;
        out_q.last         <= 1'b1;
      end else if (cmd_i.emit_can) begin
        out_q.status       <= ST_OK;
        out_q.out_task_id  <= req_q.task_id;
        out_q.priority_res <= '0;
        out_q.last         <= (cnt_q == '0);
      end else begin
        out_q.status       <= ST_OK;
        out_q.out_task_id  <= best_task_q;
        out_q.priority_res <= prio;
        out_q.last         <= (rank_q + 1'b1 == cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      rank_q      <= '0;
      best_q      <= '0;
      best_per_q  <= '0;
      best_task_q <= '0;
      best_ok_q   <= 1'b0;
      used_q      <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit_err || cmd_i.emit_can || cmd_i.emit_rank) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
      if (cmd_i.err_code != ST_OK) err_q <= cmd_i.err_code;
      idx_q <= idx_d;
      if (cmd_i.append) cnt_q <= cnt_q + 1'b1;
      if (cmd_i.dec_count) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.clr_rank) begin
        rank_q    <= '0;
        used_q    <= '0;
        best_ok_q <= 1'b0;
      end
      // strict less keeps the earliest slot on equal periods
      if (cmd_i.rank_step) begin
        if (!used_q[idx_q] && (!best_ok_q || rd_per_q < best_per_q)) begin
          best_q      <= idx_q;
          best_per_q  <= rd_per_q;
          best_task_q <= rd_task_q;
          best_ok_q   <= 1'b1;
        end
      end
      if (cmd_i.take_min) begin
        used_q[best_q] <= 1'b1;
        rank_q    <= rank_q + 1'b1;
        best_ok_q <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_q;
  assign out_data  = out_q;

endmodule
`default_nettype wire

>>> rtl/rmrt_checker.sv
`default_nettype none
module rmrt_checker
  import rmrt_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input out_word_t out_data
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != ST_OK |-> out_data.last)
    else $error("error word not last");

  a_err_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != ST_OK |-> out_data.priority_res == '0)
    else $error("error word has priority");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("took second request");

endmodule

bind rate_monotonic_reservation_table rmrt_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

>>> dv/rate_monotonic_reservation_table_tb.sv
`default_nettype none
module rate_monotonic_reservation_table_tb;
  import rmrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom   = 108;
  localparam int unsigned IdleLimit   = 200000;
  localparam int unsigned DrainCycles = 6000;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam logic [TaskW-1:0] TaskMax = {TaskW{1'b1}};

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  rate_monotonic_reservation_table DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // shadow copy of the reservation table, packed in insertion order
  logic [TaskW-1:0] resv_task[$];
  logic [TimeW-1:0] resv_period[$];

  out_word_t words_due[$];
  int        errors;
  int        quiet_cycles = 0;
  bit        no_idle;
  bit        stall_rx;

  function automatic out_word_t mk_word(status_e st, logic [TaskW-1:0] id,
                                        int prio, bit lst);
    out_word_t w;
    w.status       = st;
    w.out_task_id  = id;
    w.priority_res = prio[PrioW-1:0];
    w.last         = lst;
    return w;
  endfunction

  // stable rank by ascending period, earlier insertion wins ties
  function automatic void queue_ranking();
    int order[$];
    int j;
    int prio;
    for (int i = 0; i < resv_task.size(); i++) begin
      j = order.size();
      while (j > 0 && resv_period[order[j-1]] > resv_period[i]) j--;
      order.insert(j, i);
    end
    foreach (order[i]) begin
      prio = int'(TopPriority) - i;
      if (prio < 1) prio = 1;
      words_due.push_back(mk_word(ST_OK, resv_task[order[i]], prio,
                                  i == order.size() - 1));
    end
  endfunction

  function automatic int find_task(logic [TaskW-1:0] id);
    foreach (resv_task[i]) if (resv_task[i] == id) return i;
    return -1;
  endfunction

  function automatic void predict_table(in_word_t w);
    int s;
    case (op_e'(w.op))
      OP_RESERVE: begin
        if (w.budget_ns == 0 || w.period_ns == 0 || w.budget_ns > w.period_ns)
          words_due.push_back(mk_word(ST_TIMES, w.task_id, 0, 1'b1));
        else if (!w.task_exists)
          words_due.push_back(mk_word(ST_NOTASK, w.task_id, 0, 1'b1));
        else if (find_task(w.task_id) >= 0)
          words_due.push_back(mk_word(ST_DUP, w.task_id, 0, 1'b1));
        else if (resv_task.size() >= MaxEntries)
          words_due.push_back(mk_word(ST_FULL, w.task_id, 0, 1'b1));
        else begin
          resv_task.push_back(w.task_id);
          resv_period.push_back(w.period_ns);
          queue_ranking();
        end
      end
      OP_CANCEL: begin
        s = find_task(w.task_id);
        if (s < 0) begin
          words_due.push_back(mk_word(ST_NOTFOUND, w.task_id, 0, 1'b1));
        end else begin
          resv_task.delete(s);
          resv_period.delete(s);
          words_due.push_back(mk_word(ST_OK, w.task_id, 0, resv_task.size() == 0));
          queue_ranking();
        end
      end
      OP_EXIT: begin
        s = find_task(w.task_id);
        if (s >= 0) begin
          resv_task.delete(s);
          resv_period.delete(s);
        end
        queue_ranking();
      end
      default: ;
    endcase
  endfunction

  // result side: random stalls, checked at the rising edge
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        $error("unexpected word: status %0d id %0h", out_data.status,
               out_data.out_task_id);
        errors++;
      end else begin
        exp_w = words_due.pop_front();
        if (out_data.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, out_data.status);
          errors++;
        end
        if (out_data.out_task_id !== exp_w.out_task_id) begin
          $error("out_task_id: expected %0h, got %0h", exp_w.out_task_id,
                 out_data.out_task_id);
          errors++;
        end
        if (out_data.priority_res !== exp_w.priority_res) begin
          $error("priority_res: expected %0d, got %0d", exp_w.priority_res,
                 out_data.priority_res);
          errors++;
        end
        if (out_data.last !== exp_w.last) begin
          $error("last: expected %0b, got %0b", exp_w.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_ready <= no_idle || !stall_rx || ($urandom_range(99) >= 16);
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("rate_monotonic_reservation_table regression: fail");
      $finish;
    end
  end

  // hand one word to the block, with random gaps before it
  task automatic send_word(in_word_t w);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 16) @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    predict_table(w);
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words_due.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_word_t mk_in(op_e op, logic [TaskW-1:0] id,
                                     logic [TimeW-1:0] c, logic [TimeW-1:0] t,
                                     bit ex);
    in_word_t w;
    w.op          = op;
    w.task_id     = id;
    w.budget_ns   = c;
    w.period_ns   = t;
    w.task_exists = ex;
    return w;
  endfunction

  // directed rows; rows with a typed expectation are also cross-checked
  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } row_t;

  row_t rows[$];

  task automatic add_row(in_word_t w, bit typed = 0, status_e st = ST_OK,
                         int prio = 0, bit lst = 1);
    row_t r;
    r.word  = w;
    r.typed = typed;
    r.want  = mk_word(st, w.task_id, prio, lst);
    rows.push_back(r);
  endtask

  // random period from a few bands so ties and extremes turn up
  function automatic logic [TimeW-1:0] rand_period();
    case ($urandom_range(3))
      0: return TimeW'($urandom_range(1, 8));
      1: return TimeMax - TimeW'($urandom_range(3));
      default: return TimeW'({$urandom, $urandom});
    endcase
  endfunction

  in_word_t w;
  int       n_sent;
  int       slot;
  logic [TaskW-1:0] id_pool[$];

  initial begin
    errors     = 0;
    no_idle    = 0;
    stall_rx   = 1;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // error codes and extremes
    add_row(mk_in(OP_RESERVE, 22'h1, 0, 100, 1), 1, ST_TIMES);
    add_row(mk_in(OP_RESERVE, 22'h1, 5, 0, 1), 1, ST_TIMES);
    add_row(mk_in(OP_RESERVE, 22'h1, 101, 100, 1), 1, ST_TIMES);
    add_row(mk_in(OP_RESERVE, TaskMax, 1, TimeMax, 0), 1, ST_NOTASK);
    add_row(mk_in(OP_CANCEL, TaskMax, 0, 0, 0), 1, ST_NOTFOUND);
    add_row(mk_in(OP_EXIT, 22'h5, 0, 0, 0));
    add_row(mk_in(OP_NONE, TaskMax, TimeMax, TimeMax, 1));
    add_row(mk_in(OP_RESERVE, TaskMax, TimeMax, TimeMax, 1), 1, ST_OK, 99, 1);
    add_row(mk_in(OP_RESERVE, TaskMax, 1, 1, 1), 1, ST_DUP);
    add_row(mk_in(OP_RESERVE, 22'h0, 1, 1, 1));
    add_row(mk_in(OP_RESERVE, 22'h2AAAAA, 7, 50, 1));
    add_row(mk_in(OP_RESERVE, 22'h155555, 50, 50, 1));
    add_row(mk_in(OP_EXIT, 22'h3, 0, 0, 0));
    add_row(mk_in(OP_CANCEL, 22'h0, TimeMax, TimeMax, 1));
    add_row(mk_in(OP_EXIT, 22'h2AAAAA, 0, 0, 1));
    add_row(mk_in(OP_CANCEL, 22'h155555, 0, 0, 0));
    add_row(mk_in(OP_CANCEL, TaskMax, 0, 0, 0), 1, ST_OK, 0, 1);
    add_row(mk_in(OP_RESERVE, 22'h9, 3, 3, 1));
    add_row(mk_in(OP_EXIT, 22'h9, 0, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        wait_drained();
        predict_table(mk_in(OP_NONE, 0, 0, 0, 0));
        send_word(rows[i].word);
        if (words_due.size() == 0 || words_due[0] !== rows[i].want) begin
          $error("directed row %0d: predicted word differs from table", i);
          errors++;
        end
      end else begin
        send_word(rows[i].word);
      end
    end
    wait_drained();

    // fill the table past full, then random traffic
    for (int i = 0; i < MaxEntries + 2; i++) begin
      w = mk_in(OP_RESERVE, TaskW'($urandom), 1, rand_period(), 1);
      w.budget_ns = TimeW'($urandom_range(1, 1)) ;
      id_pool.push_back(w.task_id);
      send_word(w);
    end
    // sender holds off until the block has drained
    wait_drained();
    no_idle = 1;
    for (int i = 0; i < 30; i++) begin
      send_word(mk_in(OP_EXIT, id_pool[$urandom_range(id_pool.size() - 1)],
                      0, 0, 0));
    end
    no_idle = 0;

    n_sent = 0;
    while (n_sent < NumRandom) begin
      if ($urandom_range(9) == 0) w = mk_in(op_e'($urandom_range(3)), TaskW'($urandom),
                                          TimeW'({$urandom, $urandom}),
                                          TimeW'({$urandom, $urandom}),
                                          $urandom_range(1));
      else begin
        w.op = ($urandom_range(1) == 0) ? OP_RESERVE :
               ($urandom_range(1) == 0) ? OP_CANCEL : OP_EXIT;
        w.task_id = ($urandom_range(2) == 0) ? TaskW'($urandom) :
                    id_pool[$urandom_range(id_pool.size() - 1)];
        w.period_ns = rand_period();
        w.budget_ns = ($urandom_range(15) == 0) ? w.period_ns + 1 :
                      TimeW'($urandom_range(1, 1)) + (w.period_ns >> ($urandom_range(6)));
        if (w.budget_ns > w.period_ns && $urandom_range(3) != 0) w.budget_ns = w.period_ns;
        w.task_exists = ($urandom_range(15) != 0);
        if ($urandom_range(3) == 0) id_pool.push_back(w.task_id);
      end
      w.task_id = w.task_id & TaskMax;
      w.budget_ns = w.budget_ns & TimeMax;
      w.period_ns = w.period_ns & TimeMax;
      slot = n_sent;
      stall_rx = !(slot >= 40 && slot < 70);
      no_idle  = (slot >= 40 && slot < 70);
      send_word(w);
      if (w.op != OP_NONE) n_sent++;
    end
    no_idle  = 0;
    stall_rx = 1;

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (errors == 0 && words_due.size() == 0) begin
      $display("rate_monotonic_reservation_table regression: pass");
    end else begin
      $display("rate_monotonic_reservation_table regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
